// ----- design/random_walk_breakpoint_waveshaper_assert.svh -----
// Assertion macros used by the checker file.
`ifndef RANDOM_WALK_BREAKPOINT_WAVESHAPER_ASSERT_SVH
`define RANDOM_WALK_BREAKPOINT_WAVESHAPER_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define RWBW_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rwbw: assertion failed");

// Next-cycle implication, disabled while reset is held.
`define RWBW_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rwbw: assertion failed");

`endif

// ----- design/rwbw_pkg.sv -----
package rwbw_pkg;

    localparam int NUM_POINTS_DEF = 8;
    localparam int Q_ONE          = 32768;

    localparam logic [31:0] LFSR_TAPS = 32'h8020_0003;

    localparam logic [14:0] STEP_SIZE_RST    = 15'd33;
    localparam logic [13:0] MIN_DISTANCE_RST = 14'd328;
    localparam logic [15:0] WAIT_COUNT_RST   = 16'd1024;
    localparam logic [31:0] NOISE_SEED_RST   = 32'd1;

    localparam int APB_AW = 4;
    localparam int APB_DW = 32;

    typedef enum logic [1:0] {
        REG_STEP_SIZE    = 2'd0,
        REG_MIN_DISTANCE = 2'd1,
        REG_WAIT_COUNT   = 2'd2,
        REG_NOISE_SEED   = 2'd3
    } t_reg_idx;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SEARCH,
        S_LOAD_HI,
        S_LOAD_LO,
        S_MUL,
        S_DIV_START,
        S_DIV_WAIT,
        S_SUM,
        S_OUT,
        S_W_CUR,
        S_W_LO,
        S_W_HI
    } t_state;

    typedef struct packed {
        logic signed [15:0] sample_in;
        logic               end_of_buffer;
    } t_in;

    typedef struct packed {
        logic signed [15:0] sample_out;
        logic               end_of_buffer_out;
    } t_out;

    typedef struct packed {
        logic [14:0] step_size;
        logic [13:0] min_distance;
        logic [15:0] wait_count;
        logic [31:0] noise_seed;
        logic        seed_load;
    } t_cfg;

    function automatic logic [31:0] lfsr_next(input logic [31:0] s);
        logic [31:0] t;
        t = s >> 1;
        if (s[0]) begin
            t = t ^ LFSR_TAPS;
        end
        return t;
    endfunction

    function automatic logic signed [15:0] sat16(input logic signed [33:0] v);
        logic signed [15:0] r;
        if (v < -34'sd32768) begin
            r = -16'sd32768;
        end else if (v > 34'sd32767) begin
            r = 16'sd32767;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

endpackage

// ----- design/rwbw_div.sv -----
module rwbw_div #(
    parameter int NW = 32,
    parameter int DW = 17
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    output logic          o_done,
    output logic [NW-1:0] o_quot
);
    localparam int CW = $clog2(NW + 1);

    logic          r_busy;
    logic [CW-1:0] r_cnt;
    logic [NW-1:0] r_q;
    logic [DW-1:0] r_rem;
    logic [DW-1:0] r_den;
    logic [DW:0]   w_rem_sh;
    logic [DW:0]   w_diff;

    assign w_rem_sh = {r_rem, r_q[NW-1]};
    assign w_diff   = w_rem_sh - {1'b0, r_den};
    assign o_done   = r_busy && (r_cnt == CW'(NW - 1));
    assign o_quot   = r_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_busy <= !o_done;
            r_cnt  <= r_cnt + 1'b1;
        end
    end

    // one quotient bit per cycle, restoring
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            if (!w_diff[DW]) begin
                r_rem <= w_diff[DW-1:0];
                r_q   <= {r_q[NW-2:0], 1'b1};
            end else begin
                r_rem <= w_rem_sh[DW-1:0];
                r_q   <= {r_q[NW-2:0], 1'b0};
            end
        end
    end

endmodule

// ----- design/rwbw_core.sv -----
module rwbw_core #(
    parameter int NUM_POINTS = rwbw_pkg::NUM_POINTS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  rwbw_pkg::t_cfg i_cfg,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  rwbw_pkg::t_in  i_in,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output rwbw_pkg::t_out o_out
);
    import rwbw_pkg::*;

    localparam int AW = $clog2(NUM_POINTS);
    localparam int IW = $clog2(NUM_POINTS + 1);
    localparam logic [AW-1:0] LAST    = AW'(NUM_POINTS - 1);
    localparam logic [IW-1:0] SEG_TOP = IW'(NUM_POINTS);
    localparam logic signed [17:0] END_LO = -18'sd32768;
    localparam logic signed [17:0] END_HI = 18'sd32768;
    localparam logic signed [18:0] END_LO_W = -19'sd32768;
    localparam logic signed [18:0] END_HI_W = 19'sd32768;

    t_state r_state, n_state;

    logic signed [15:0] r_bx [NUM_POINTS];
    logic signed [15:0] r_by [NUM_POINTS];
    logic signed [15:0] w_rst [NUM_POINTS];

    logic [15:0] r_cnt;
    logic [31:0] r_lfsr;
    logic        r_out_valid;
    t_out        r_out;

    logic [IW-1:0]      r_idx, r_seg;
    logic               r_top;
    logic signed [15:0] r_v;
    logic               r_eob;
    logic signed [17:0] r_x0, r_y0, r_x1, r_y1;
    logic signed [35:0] r_prod;
    logic signed [17:0] r_den;
    logic               r_neg, r_zero;
    logic signed [15:0] r_res;

    logic [AW-1:0]      r_widx;
    logic               r_wy;
    logic signed [15:0] r_cur;
    logic signed [31:0] r_mprod;
    logic signed [18:0] r_wv, r_lo;

    logic [AW-1:0]      w_addr;
    logic signed [15:0] w_rd_x, w_rd_y, w_rd_a;
    logic               w_hit;
    logic               w_div_start, w_div_done, w_out_load, w_walk_due;
    logic [31:0]        w_num_mag, w_quot, w_lfsr_n;
    logic [16:0]        w_den_mag;
    logic signed [17:0] w_dv, w_dy;
    logic signed [32:0] w_q;
    logic signed [18:0] w_md, w_hi, w_v1, w_v2;
    logic signed [15:0] w_wnew;

    for (genvar g = 0; g < NUM_POINTS; g++) begin : g_rst
        localparam int RX = (65536 * (g + 1) + (NUM_POINTS + 1) / 2) / (NUM_POINTS + 1) - Q_ONE;
        assign w_rst[g] = 16'(RX);
    end

    // single read port into the breakpoint registers
    always_comb begin
        unique case (r_state)
            S_W_CUR: w_addr = r_widx;
            S_W_LO:  w_addr = (r_widx == '0) ? r_widx : r_widx - 1'b1;
            S_W_HI:  w_addr = (r_widx == LAST) ? r_widx : r_widx + 1'b1;
            default: w_addr = r_idx[AW-1:0];
        endcase
    end

    assign w_rd_x   = r_bx[w_addr];
    assign w_rd_y   = r_by[w_addr];
    assign w_rd_a   = r_wy ? w_rd_y : w_rd_x;
    assign w_hit    = (r_v <= w_rd_x);
    assign w_lfsr_n = lfsr_next(r_lfsr);
    assign w_walk_due = !(r_cnt < i_cfg.wait_count);

    assign w_dv = 18'(r_v) - r_x0;
    assign w_dy = r_y1 - r_y0;
    assign w_num_mag = r_prod[35] ? 32'(-r_prod) : r_prod[31:0];
    assign w_den_mag = r_den[17] ? 17'(-r_den) : r_den[16:0];
    assign w_q = r_neg ? -$signed({1'b0, w_quot}) : $signed({1'b0, w_quot});

    assign w_md = $signed({5'b0, i_cfg.min_distance});
    assign w_hi = (r_widx == LAST) ? END_HI_W - w_md : 19'(w_rd_a) - w_md;
    assign w_v1 = (r_wv < r_lo) ? r_lo : r_wv;
    assign w_v2 = (w_v1 > w_hi) ? w_hi : w_v1;
    assign w_wnew = sat16(34'(w_v2));

    rwbw_div #(.NW(32), .DW(17)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_num_mag),
        .i_den   (w_den_mag),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:      if (i_in_valid) n_state = S_SEARCH;
            S_SEARCH:    if (r_top ? !w_hit : w_hit) n_state = S_LOAD_HI;
            S_LOAD_HI:   n_state = S_LOAD_LO;
            S_LOAD_LO:   n_state = S_MUL;
            S_MUL:       n_state = S_DIV_START;
            S_DIV_START: n_state = (r_den == '0) ? S_SUM : S_DIV_WAIT;
            S_DIV_WAIT:  if (w_div_done) n_state = S_SUM;
            S_SUM:       n_state = S_OUT;
            S_OUT:       if (w_out_load) n_state = w_walk_due ? S_W_CUR : S_IDLE;
            S_W_CUR:     n_state = S_W_LO;
            S_W_LO:      n_state = S_W_HI;
            S_W_HI:      n_state = (r_wy && r_widx == LAST) ? S_IDLE : S_W_CUR;
            default:     n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready  = (r_state == S_IDLE);
        w_div_start = (r_state == S_DIV_START) && (r_den != '0);
        w_out_load  = (r_state == S_OUT) && (!r_out_valid || i_out_ready);
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_cnt       <= '0;
            r_lfsr      <= NOISE_SEED_RST;
            for (int i = 0; i < NUM_POINTS; i++) begin
                r_bx[i] <= w_rst[i];
                r_by[i] <= w_rst[i];
            end
        end else begin
            r_state <= n_state;
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (w_out_load) begin
                r_cnt <= w_walk_due ? '0 : r_cnt + 1'b1;
            end
            if (i_cfg.seed_load) begin
                r_lfsr <= (i_cfg.noise_seed != '0) ? i_cfg.noise_seed : 32'd1;
            end else if (r_state == S_W_CUR) begin
                r_lfsr <= w_lfsr_n;
            end
            if (r_state == S_W_HI) begin
                if (r_wy) begin
                    r_by[r_widx] <= w_wnew;
                end else begin
                    r_bx[r_widx] <= w_wnew;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                r_v   <= i_in.sample_in;
                r_eob <= i_in.end_of_buffer;
                r_idx <= IW'(LAST);
                r_top <= 1'b1;
            end
            S_SEARCH: begin
                if (r_top) begin
                    // probe the last point first: anything above it takes the top segment
                    if (w_hit) begin
                        r_top <= 1'b0;
                        r_idx <= '0;
                    end else begin
                        r_seg <= SEG_TOP;
                    end
                end else if (w_hit) begin
                    r_seg <= r_idx;
                end else begin
                    r_idx <= r_idx + 1'b1;
                end
            end
            S_LOAD_HI: begin
                r_x1  <= (r_seg == SEG_TOP) ? END_HI : 18'(w_rd_x);
                r_y1  <= (r_seg == SEG_TOP) ? END_HI : 18'(w_rd_y);
                r_idx <= (r_seg == '0) ? '0 : r_seg - 1'b1;
            end
            S_LOAD_LO: begin
                r_x0 <= (r_seg == '0) ? END_LO : 18'(w_rd_x);
                r_y0 <= (r_seg == '0) ? END_LO : 18'(w_rd_y);
            end
            S_MUL: begin
                r_prod <= w_dv * w_dy;
                r_den  <= r_x1 - r_x0;
            end
            S_DIV_START: begin
                r_neg  <= r_prod[35] ^ r_den[17];
                r_zero <= (r_den == '0);
            end
            S_SUM: begin
                r_res <= r_zero ? sat16(34'(r_y0)) : sat16(34'(r_y0) + 34'(w_q));
            end
            S_OUT: begin
                if (w_out_load) begin
                    r_out.sample_out        <= r_res;
                    r_out.end_of_buffer_out <= r_eob;
                    r_widx                  <= '0;
                    r_wy                    <= 1'b0;
                end
            end
            S_W_CUR: begin
                r_cur   <= w_rd_a;
                r_mprod <= $signed({1'b0, i_cfg.step_size}) * $signed(w_lfsr_n[15:0]);
            end
            S_W_LO: begin
                // floor of the scaled step is the arithmetic shift
                r_wv <= 19'(r_cur) + 19'($signed(r_mprod[31:15]));
                r_lo <= (r_widx == '0) ? END_LO_W + w_md : 19'(w_rd_a) + w_md;
            end
            S_W_HI: begin
                if (r_wy) begin
                    r_wy   <= 1'b0;
                    r_widx <= r_widx + 1'b1;
                end else begin
                    r_wy <= 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

endmodule

// ----- design/random_walk_breakpoint_waveshaper.sv -----
// Channel   Direction  Handshake                  Payload
// in        input      i_in_valid / o_in_ready    i_in  (sample_in, end_of_buffer)
// out       output     o_out_valid / i_out_ready  o_out (sample_out, end_of_buffer_out)
// cfg       input      psel/penable/pwrite/pready paddr, pwdata, prdata
//
// A sample goes through a probe of the last point, then a one-point-a-cycle segment
// search, then a serial divider (skipped for a zero-width segment) sets the figure.
// Every wait_count+1 samples a walk follows, stepping each coordinate through
// S_W_CUR, S_W_LO and S_W_HI.
// Synchronous reset loads the identity breakpoints and the reset register values.
// A result waits in the output register; the next sample is taken meanwhile.
module random_walk_breakpoint_waveshaper #(
    parameter int NUM_POINTS = rwbw_pkg::NUM_POINTS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  rwbw_pkg::t_in                 i_in,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output rwbw_pkg::t_out                o_out,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [rwbw_pkg::APB_AW-1:0]   paddr,
    input  logic [rwbw_pkg::APB_DW-1:0]   pwdata,
    output logic [rwbw_pkg::APB_DW-1:0]   prdata,
    output logic                          pready
);
    import rwbw_pkg::*;

    logic [14:0] r_step_size;
    logic [13:0] r_min_distance;
    logic [15:0] r_wait_count;
    logic [31:0] r_noise_seed;
    logic        w_wr;
    t_reg_idx    w_idx;
    t_cfg        w_cfg;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;
    assign w_idx  = t_reg_idx'(paddr[3:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step_size    <= STEP_SIZE_RST;
            r_min_distance <= MIN_DISTANCE_RST;
            r_wait_count   <= WAIT_COUNT_RST;
            r_noise_seed   <= NOISE_SEED_RST;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_STEP_SIZE:    r_step_size    <= pwdata[14:0];
                REG_MIN_DISTANCE: r_min_distance <= pwdata[13:0];
                REG_WAIT_COUNT:   r_wait_count   <= pwdata[15:0];
                REG_NOISE_SEED:   r_noise_seed   <= pwdata;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_STEP_SIZE:    prdata = {17'b0, r_step_size};
            REG_MIN_DISTANCE: prdata = {18'b0, r_min_distance};
            REG_WAIT_COUNT:   prdata = {16'b0, r_wait_count};
            REG_NOISE_SEED:   prdata = r_noise_seed;
        endcase
    end

    always_comb begin
        w_cfg.step_size    = r_step_size;
        w_cfg.min_distance = r_min_distance;
        w_cfg.wait_count   = r_wait_count;
        // reload the noise register straight from the bus value
        w_cfg.noise_seed   = pwdata;
        w_cfg.seed_load    = w_wr && (w_idx == REG_NOISE_SEED) && i_rst_n;
    end

    rwbw_core #(.NUM_POINTS(NUM_POINTS)) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (w_cfg),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

endmodule

// ----- design/rwbw_checker.sv -----
`include "random_walk_breakpoint_waveshaper_assert.svh"

module rwbw_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_in_valid,
    input logic           o_in_ready,
    input logic           o_out_valid,
    input logic           i_out_ready,
    input rwbw_pkg::t_out o_out
);

    // one sample at a time: busy right after a transaction
    `RWBW_ASSERT_NXT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && o_in_ready, !o_in_ready)

    // a result never appears in the cycle after its sample is taken
    `RWBW_ASSERT_NXT(a_no_instant_result, i_clk, i_rst_n, i_in_valid && o_in_ready, !$rose(o_out_valid))

    // hold a stalled result
    `RWBW_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_out))

endmodule

bind random_walk_breakpoint_waveshaper rwbw_checker u_rwbw_checker (.*);

// ----- test/tb_random_walk_breakpoint_waveshaper.sv -----
`timescale 1ns / 100ps

module tb_random_walk_breakpoint_waveshaper;
    import rwbw_pkg::*;

    localparam int NP = NUM_POINTS_DEF;
    localparam int WALK_SETTLE = 6 * NP + NP + 60;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    t_in         i_in = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    t_out        o_out;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [APB_AW-1:0] paddr = '0;
    logic [APB_DW-1:0] pwdata = '0;
    logic [APB_DW-1:0] prdata;
    logic        pready;

    random_walk_breakpoint_waveshaper dut (.*);

    always #1 i_clk = ~i_clk;

    // shaper model state
    int          bx[NP];
    int          by[NP];
    int unsigned wait_ctr;
    logic [31:0] noise;
    int unsigned step_amp, min_gap, walk_period;

    t_in  sample_q[$];
    t_out shaped_q[$];
    int   errors = 0;
    int   n_sent = 0, n_got = 0, n_walks = 0;
    bit   calm = 1'b0;

    function automatic int sat_q15(longint v);
        if (v < -32768) return -32768;
        if (v > 32767) return 32767;
        return int'(v);
    endfunction

    function automatic int line_map(int v, int x0, int y0, int x1, int y1);
        longint q;
        if (x1 == x0) return sat_q15(y0);
        q = (longint'(v - x0) * longint'(y1 - y0)) / longint'(x1 - x0);
        return sat_q15(longint'(y0) + q);
    endfunction

    function automatic int noise_move();
        logic [31:0] s;
        int r;
        longint p;
        s = noise >> 1;
        if (noise[0]) s = s ^ 32'h8020_0003;
        noise = s;
        r = int'($signed(s[15:0]));
        p = longint'(step_amp) * r;
        if (p >= 0) return int'(p >>> 15);
        return -int'((-p + 32767) >>> 15);
    endfunction

    function automatic void nudge(ref int a[NP], input int i);
        int v, lo, hi;
        v = a[i] + noise_move();
        lo = (i == 0) ? -32768 + int'(min_gap) : a[i-1] + int'(min_gap);
        hi = (i == NP - 1) ? 32768 - int'(min_gap) : a[i+1] - int'(min_gap);
        if (v < lo) v = lo;
        if (v > hi) v = hi;
        a[i] = sat_q15(v);
    endfunction

    function automatic t_out shape_sample(t_in s);
        t_out o;
        int v, r, seg;
        v = int'(s.sample_in);
        if (v <= bx[0]) begin
            r = line_map(v, -32768, -32768, bx[0], by[0]);
        end else if (v > bx[NP-1]) begin
            r = line_map(v, bx[NP-1], by[NP-1], 32768, 32768);
        end else begin
            seg = NP - 1;
            for (int i = 1; i < NP; i++) begin
                if (v <= bx[i]) begin
                    seg = i;
                    break;
                end
            end
            r = line_map(v, bx[seg-1], by[seg-1], bx[seg], by[seg]);
        end
        o.sample_out = r[15:0];
        o.end_of_buffer_out = s.end_of_buffer;
        if (wait_ctr < walk_period) begin
            wait_ctr = (wait_ctr + 1) & 16'hFFFF;
        end else begin
            for (int i = 0; i < NP; i++) begin
                nudge(bx, i);
                nudge(by, i);
            end
            wait_ctr = 0;
            n_walks++;
        end
        return o;
    endfunction

    function automatic void model_reset();
        step_amp = STEP_SIZE_RST;
        min_gap = MIN_DISTANCE_RST;
        walk_period = WAIT_COUNT_RST;
        noise = NOISE_SEED_RST;
        for (int i = 0; i < NP; i++) begin
            bx[i] = int'((longint'(65536) * (i + 1) + (NP + 1) / 2) / (NP + 1)) - 32768;
            by[i] = bx[i];
        end
        wait_ctr = 0;
    endfunction

    task automatic reg_write(t_reg_idx idx, logic [31:0] val);
        @(posedge i_clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= APB_AW'(4 * int'(idx));
        pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_STEP_SIZE:    step_amp = val[14:0];
            REG_MIN_DISTANCE: min_gap = val[13:0];
            REG_WAIT_COUNT:   walk_period = val[15:0];
            REG_NOISE_SEED:   noise = (val == 0) ? 32'd1 : val;
            default: ;
        endcase
    endtask

    task automatic drain();
        int guard;
        guard = 0;
        while ((sample_q.size() != 0 || shaped_q.size() != 0 || i_in_valid)
               && guard < 200000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (WALK_SETTLE) @(posedge i_clk);
    endtask

    // feed model at acceptance time so predictions follow the register set in force
    int gap_in = 0;
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                shaped_q.push_back(shape_sample(i_in));
                n_sent++;
            end
            if (!i_in_valid || o_in_ready) begin
                if (gap_in > 0) begin
                    gap_in <= gap_in - 1;
                    i_in_valid <= 1'b0;
                end else if (sample_q.size() != 0) begin
                    i_in <= sample_q.pop_front();
                    i_in_valid <= 1'b1;
                    if (!calm && $urandom_range(0, 5) == 0) gap_in <= $urandom_range(1, 10);
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    int stall_out = 0;
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                t_out want;
                n_got++;
                if (shaped_q.size() == 0) begin
                    $error("unexpected result sample_out=%0d", o_out.sample_out);
                    errors++;
                end else begin
                    want = shaped_q.pop_front();
                    if (o_out.sample_out !== want.sample_out) begin
                        $error("sample_out: expected %0d, got %0d",
                               want.sample_out, o_out.sample_out);
                        errors++;
                    end
                    if (o_out.end_of_buffer_out !== want.end_of_buffer_out) begin
                        $error("end_of_buffer_out: expected %0b, got %0b",
                               want.end_of_buffer_out, o_out.end_of_buffer_out);
                        errors++;
                    end
                end
            end
            if (stall_out > 0) begin
                stall_out <= stall_out - 1;
                i_out_ready <= 1'b0;
            end else if (!calm && $urandom_range(0, 6) == 0) begin
                stall_out <= $urandom_range(0, 9);
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    // queue items while the block may still be working: each is driven when the input is free, modelled at acceptance
    function automatic void add_sample(int v, bit eob);
        t_in t;
        t.sample_in = v[15:0];
        t.end_of_buffer = eob;
        sample_q.push_back(t);
    endfunction

    function automatic void add_random(int n);
        int v;
        for (int k = 0; k < n; k++) begin
            case ($urandom_range(0, 7))
                0: v = -32768;
                1: v = 32767;
                2: v = bx[$urandom_range(0, NP - 1)] + $urandom_range(0, 2) - 1;
                default: v = int'($signed(16'($urandom())));
            endcase
            if (v > 32767) v = 32767;
            if (v < -32768) v = -32768;
            add_sample(v, $urandom_range(0, 1));
        end
    endfunction

    initial begin
        model_reset();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // extremes, breakpoints themselves and neighbors, with default walk period
        add_sample(-32768, 0);
        add_sample(32767, 1);
        add_sample(0, 0);
        add_sample(-1, 1);
        for (int i = 0; i < NP; i++) begin
            add_sample(bx[i], i[0]);
            add_sample(bx[i] + 1, 0);
        end
        add_sample(16'sh5555, 1);
        add_sample(-21846, 0);
        drain();

        // walk every sample with the widest steps and no spacing: points can collide
        reg_write(REG_STEP_SIZE, 32'h7FFF);
        reg_write(REG_MIN_DISTANCE, 0);
        reg_write(REG_WAIT_COUNT, 0);
        reg_write(REG_NOISE_SEED, 32'hDEAD_BEEF);
        add_random(120);
        drain();

        // maximal spacing forces clamps to fight; zero seed must not lock the noise
        reg_write(REG_MIN_DISTANCE, 14'h3FFF);
        reg_write(REG_NOISE_SEED, 0);
        reg_write(REG_WAIT_COUNT, 3);
        add_random(100);
        drain();

        // no step, longest period
        reg_write(REG_STEP_SIZE, 0);
        reg_write(REG_WAIT_COUNT, 16'hFFFF);
        reg_write(REG_NOISE_SEED, 32'hFFFF_FFFF);
        add_random(60);
        drain();

        // lower period below the counter: walk on next sample
        reg_write(REG_STEP_SIZE, $urandom_range(1, 32767));
        reg_write(REG_MIN_DISTANCE, $urandom_range(0, 2000));
        reg_write(REG_WAIT_COUNT, $urandom_range(0, 7));
        reg_write(REG_NOISE_SEED, $urandom());
        add_random(150);
        drain();

        calm = 1'b1;
        reg_write(REG_WAIT_COUNT, 1);
        add_random(80);
        drain();

        $display("Sent %0d samples, checked %0d results, %0d breakpoint walks",
                 n_sent, n_got, n_walks);
        if (errors == 0 && shaped_q.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("Regression FAIL");
        $finish;
    end
endmodule
